[rtl/core/assert_macros.svh]
// assertion macros of the arithmetic stage, included by its top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked on every rising clock edge out of reset
`define CAS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// antecedent in one cycle implies consequent in the next
`define CAS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/core/cas_pkg.sv]
// shared types, constants and tables of the arithmetic stage
package cas_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int MAX_SQUARINGS = 31;
  localparam int DATA_W        = 32;
  localparam int CFG_IDX_W     = 3;
  localparam int LOG_FRAC      = 24;
  localparam int MUL_W         = 34;
  localparam int PROD_W        = 2 * MUL_W;
  localparam int DVD_W         = 65;
  localparam int DVS_W         = 33;
  localparam int DCNT_W        = 7;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_MUL   = 3'd1,
    OP_DIV   = 3'd2,
    OP_POW   = 3'd3,
    OP_SQR   = 3'd4,
    OP_REMAP = 3'd5,
    OP_REPL  = 3'd6
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OP_MODE = 3'd0,
    CFG_OPERAND = 3'd1,
    CFG_SRC_LO  = 3'd2,
    CFG_SRC_HI  = 3'd3,
    CFG_TGT_LO  = 3'd4,
    CFG_TGT_HI  = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_NORM,
    ST_LOG,
    ST_LMUL,
    ST_EXP,
    ST_PFIN,
    ST_SQR,
    ST_DIV,
    ST_DONE
  } state_e;

  // divider request and response
  typedef struct packed {
    logic              start;
    logic [DCNT_W-1:0] nbits;
    logic [DVD_W-1:0]  dividend;
    logic [DVS_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DVD_W-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] val;
    logic                     ovf;
  } sat_t;

  localparam logic signed [PROD_W-1:0] S32MAX_W = PROD_W'(64'sd2147483647);
  localparam logic signed [PROD_W-1:0] S32MIN_W = -PROD_W'(64'sd2147483648);

  // clamp a wide signed value to the 32-bit range
  function automatic sat_t sat32(input logic signed [PROD_W-1:0] v);
    sat_t r;
    r.ovf = 1'b0;
    r.val = v[DATA_W-1:0];
    if (v > S32MAX_W) begin
      r.ovf = 1'b1;
      r.val = S32MAX_W[DATA_W-1:0];
    end else if (v < S32MIN_W) begin
      r.ovf = 1'b1;
      r.val = S32MIN_W[DATA_W-1:0];
    end
    return r;
  endfunction

  // integer square root, evaluated at elaboration only
  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bw;
    v   = v_in;
    res = '0;
    bw  = 64'h1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (bw > v) bw = bw >> 2;
    end
    for (int j = 0; j < 32; j++) begin
      if (bw != 64'h0) begin
        if (v >= res + bw) begin
          v   = v - (res + bw);
          res = (res >> 1) + bw;
        end else begin
          res = res >> 1;
        end
        bw = bw >> 2;
      end
    end
    return res;
  endfunction

  typedef logic [DATA_W-1:0] exp_tab_t [LOG_FRAC+1];

  // 2^(2^-i) in Q2.30 by repeated square roots from 2.0
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    t;
    logic [63:0] w;
    w    = 64'h1 << 31;
    t[0] = w[DATA_W-1:0];
    for (int i = 1; i <= LOG_FRAC; i++) begin
      w    = isqrt64(w << 30);
      t[i] = w[DATA_W-1:0];
    end
    return t;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

[rtl/core/cas_if.sv]
// item channels of the arithmetic stage: sample in, result out
interface cas_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [cas_pkg::DATA_W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface cas_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [cas_pkg::DATA_W-1:0] sample_out;
  logic                             overflow_flag;
  logic                             domain_flag;

  modport source (output valid, output sample_out, output overflow_flag,
                  output domain_flag, input ready);
  modport sink (input valid, input sample_out, input overflow_flag,
                input domain_flag, output ready);
endinterface

[rtl/core/configurable_arith_stage_unit.sv]
// top level of the configurable arithmetic stage with its sequencer
//
//  port       | direction | handshake    | payload
//  in_i       | sink      | valid/ready  | sample_in
//  out_o      | source    | valid/ready  | sample_out, overflow_flag, domain_flag
//  cfg_*      | write     | cfg_we_i     | cfg_idx_i, cfg_data_i
//
// one item at a time; in_i.ready is high only while the sequencer is idle
// add, multiply, replace: computed in the start state; repeated square: up to count squarings
// divide and remap: wait on the one-bit-per-cycle divider
// power: normalise shift, 24 log squarings, 24 exp steps
// the result sits in an output register, so a stalled sink holds only the next item
// reset clears the sequencer and the output valid and loads the configuration defaults
module configurable_arith_stage_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  cas_in_if.sink                            in_i,
  cas_out_if.source                         out_o,
  input  logic                              cfg_we_i,
  input  logic [cas_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [cas_pkg::DATA_W-1:0]        cfg_data_i
);

  localparam logic signed [cas_pkg::DATA_W-1:0] ONE_Q = 32'sd1 <<< cas_pkg::FRAC_BITS;
  localparam logic signed [cas_pkg::DATA_W-1:0] MAX_SQ_S = 32'(cas_pkg::MAX_SQUARINGS);
  localparam logic [cas_pkg::DVD_W-1:0] Q_LIM = {{(cas_pkg::DVD_W-1){1'b0}}, 1'b1} << 40;

  // configuration registers
  logic [2:0]                        op_mode_q;
  logic signed [cas_pkg::DATA_W-1:0] num_q, src_lo_q, src_hi_q, tgt_lo_q, tgt_hi_q;

  // sequencer and working registers
  cas_pkg::state_e                   state_q, state_d;
  logic signed [cas_pkg::DATA_W-1:0] x_q, x_d;
  logic [cas_pkg::DATA_W-1:0]        acc_q, acc_d;
  logic [5:0]                        cnt_q, cnt_d;
  logic [4:0]                        p_q, p_d;
  logic [cas_pkg::LOG_FRAC-1:0]      frac_q, frac_d;
  logic [cas_pkg::LOG_FRAC-1:0]      f_q, f_d;
  logic [4:0]                        sh_q, sh_d;
  logic                              neg_q, neg_d;
  logic signed [cas_pkg::DATA_W-1:0] res_q, res_d;
  logic                              ovf_q, ovf_d, dom_q, dom_d;

  // output register
  logic                              ov_q, ov_d;
  logic signed [cas_pkg::DATA_W-1:0] os_q, os_d;
  logic                              oo_q, oo_d, od_q, od_d;

  // shared multiplier
  logic signed [cas_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic signed [cas_pkg::PROD_W-1:0] prod;

  cas_pkg::div_req_t div_req;
  cas_pkg::div_rsp_t div_rsp;

  // derived operands
  logic                              n_int;
  logic [cas_pkg::DATA_W-1:0]        x_abs, n_abs;
  logic signed [cas_pkg::DATA_W:0]   dx, dr, dy;
  logic [cas_pkg::DATA_W:0]          dx_abs, dr_abs, dy_abs;
  logic signed [cas_pkg::DATA_W-1:0] c_sq;
  logic signed [cas_pkg::PROD_W-1:0] wide, e_full, k_full, s_full;
  logic [cas_pkg::DATA_W:0]          t33;
  logic [cas_pkg::DATA_W:0]          mag;
  logic [cas_pkg::DVD_W-1:0]         qc;
  logic signed [29:0]                logv;
  logic [5:0]                        tab_idx;
  cas_pkg::sat_t                     sat_r;

  cas_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign prod = mul_a * mul_b;

  // operand preparation
  always_comb begin
    n_int  = (num_q[cas_pkg::FRAC_BITS-1:0] == '0);
    x_abs  = x_q[cas_pkg::DATA_W-1] ? -x_q : x_q;
    n_abs  = num_q[cas_pkg::DATA_W-1] ? -num_q : num_q;
    dx     = {x_q[cas_pkg::DATA_W-1], x_q} - {src_lo_q[cas_pkg::DATA_W-1], src_lo_q};
    dr     = {src_hi_q[cas_pkg::DATA_W-1], src_hi_q} - {src_lo_q[cas_pkg::DATA_W-1], src_lo_q};
    dy     = {tgt_hi_q[cas_pkg::DATA_W-1], tgt_hi_q} - {tgt_lo_q[cas_pkg::DATA_W-1], tgt_lo_q};
    dx_abs = dx[cas_pkg::DATA_W] ? -dx : dx;
    dr_abs = dr[cas_pkg::DATA_W] ? -dr : dr;
    dy_abs = dy[cas_pkg::DATA_W] ? -dy : dy;
    c_sq   = num_q >>> cas_pkg::FRAC_BITS;
  end

  // sequencer: next state, datapath steps and output register
  always_comb begin
    state_d = state_q;
    x_d     = x_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    p_d     = p_q;
    frac_d  = frac_q;
    f_d     = f_q;
    sh_d    = sh_q;
    neg_d   = neg_q;
    res_d   = res_q;
    ovf_d   = ovf_q;
    dom_d   = dom_q;
    ov_d    = ov_q && !out_o.ready;
    os_d    = os_q;
    oo_d    = oo_q;
    od_d    = od_q;
    mul_a   = '0;
    mul_b   = '0;
    div_req = '0;
    wide    = '0;
    e_full  = '0;
    k_full  = '0;
    s_full  = '0;
    t33     = '0;
    mag     = '0;
    qc      = '0;
    logv    = '0;
    tab_idx = '0;
    sat_r   = '0;

    case (state_q)
      cas_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          x_d     = in_i.sample_in;
          state_d = cas_pkg::ST_START;
        end
      end

      cas_pkg::ST_START: begin
        ovf_d   = 1'b0;
        dom_d   = 1'b0;
        state_d = cas_pkg::ST_DONE;
        case (op_mode_q)
          cas_pkg::OP_ADD: begin
            wide  = cas_pkg::PROD_W'(x_q) + cas_pkg::PROD_W'(num_q);
            sat_r = cas_pkg::sat32(wide);
            res_d = sat_r.val;
            ovf_d = sat_r.ovf;
          end
          cas_pkg::OP_MUL: begin
            mul_a = cas_pkg::MUL_W'(x_q);
            mul_b = cas_pkg::MUL_W'(num_q);
            sat_r = cas_pkg::sat32(prod >>> cas_pkg::FRAC_BITS);
            res_d = sat_r.val;
            ovf_d = sat_r.ovf;
          end
          cas_pkg::OP_DIV: begin
            div_req.start    = 1'b1;
            div_req.nbits    = cas_pkg::DCNT_W'(cas_pkg::DATA_W + cas_pkg::FRAC_BITS);
            div_req.dividend = {x_abs, {(cas_pkg::DVD_W-cas_pkg::DATA_W){1'b0}}};
            div_req.divisor  = (num_q == '0) ? cas_pkg::DVS_W'(1) : {1'b0, n_abs};
            state_d          = cas_pkg::ST_DIV;
          end
          cas_pkg::OP_POW: begin
            // zero base, then negative base with a fractional exponent
            if (x_q == '0) begin
              if (num_q == '0) begin
                res_d = ONE_Q;
              end else if (num_q[cas_pkg::DATA_W-1]) begin
                res_d = cas_pkg::S32MAX_W[cas_pkg::DATA_W-1:0];
                ovf_d = 1'b1;
              end else begin
                res_d = '0;
              end
            end else if (x_q[cas_pkg::DATA_W-1] && !n_int) begin
              res_d = '0;
              dom_d = 1'b1;
            end else begin
              acc_d   = x_abs;
              p_d     = 5'd31;
              neg_d   = x_q[cas_pkg::DATA_W-1] && num_q[cas_pkg::FRAC_BITS];
              state_d = cas_pkg::ST_NORM;
            end
          end
          cas_pkg::OP_SQR: begin
            if (c_sq <= 0) begin
              res_d = x_q;
            end else begin
              cnt_d   = (c_sq > MAX_SQ_S) ? 6'(cas_pkg::MAX_SQUARINGS) : c_sq[5:0];
              acc_d   = x_q;
              state_d = cas_pkg::ST_SQR;
            end
          end
          cas_pkg::OP_REMAP: begin
            if (dr == '0) begin
              res_d = '0;
              dom_d = 1'b1;
            end else begin
              mul_a            = {1'b0, dx_abs};
              mul_b            = {1'b0, dy_abs};
              div_req.start    = 1'b1;
              div_req.nbits    = cas_pkg::DCNT_W'(cas_pkg::DVD_W);
              div_req.dividend = prod[cas_pkg::DVD_W-1:0];
              div_req.divisor  = dr_abs;
              state_d          = cas_pkg::ST_DIV;
            end
          end
          cas_pkg::OP_REPL: begin
            res_d = num_q;
          end
          default: begin
            res_d = x_q;
          end
        endcase
      end

      // shift the magnitude up until its top bit is set
      cas_pkg::ST_NORM: begin
        if (acc_q[cas_pkg::DATA_W-1]) begin
          cnt_d   = 6'(cas_pkg::LOG_FRAC);
          frac_d  = '0;
          state_d = cas_pkg::ST_LOG;
        end else begin
          acc_d = {acc_q[cas_pkg::DATA_W-2:0], 1'b0};
          p_d   = p_q - 1'b1;
        end
      end

      // one log2 fraction bit per squaring of the mantissa
      cas_pkg::ST_LOG: begin
        mul_a  = {2'b00, acc_q};
        mul_b  = {2'b00, acc_q};
        t33    = prod[31 +: cas_pkg::DATA_W+1];
        acc_d  = t33[cas_pkg::DATA_W] ? t33[cas_pkg::DATA_W:1] : t33[cas_pkg::DATA_W-1:0];
        frac_d = {frac_q[cas_pkg::LOG_FRAC-2:0], t33[cas_pkg::DATA_W]};
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == 6'd1) begin
          state_d = cas_pkg::ST_LMUL;
        end
      end

      // exponent times log2, split into integer and fraction
      cas_pkg::ST_LMUL: begin
        logv   = {6'({1'b0, p_q}) - 6'(cas_pkg::FRAC_BITS), frac_q};
        mul_a  = cas_pkg::MUL_W'(num_q);
        mul_b  = cas_pkg::MUL_W'(logv);
        e_full = prod >>> cas_pkg::FRAC_BITS;
        k_full = e_full >>> cas_pkg::LOG_FRAC;
        s_full = k_full + cas_pkg::PROD_W'(cas_pkg::FRAC_BITS);
        f_d    = e_full[cas_pkg::LOG_FRAC-1:0];
        sh_d   = 5'(cas_pkg::PROD_W'(30) - s_full);
        acc_d  = cas_pkg::DATA_W'(1) << 30;
        cnt_d  = 6'(cas_pkg::LOG_FRAC);
        if (s_full >= cas_pkg::PROD_W'(31)) begin
          res_d   = neg_q ? cas_pkg::S32MIN_W[cas_pkg::DATA_W-1:0]
                          : cas_pkg::S32MAX_W[cas_pkg::DATA_W-1:0];
          ovf_d   = 1'b1;
          state_d = cas_pkg::ST_DONE;
        end else if (s_full < -cas_pkg::PROD_W'(1)) begin
          res_d   = '0;
          state_d = cas_pkg::ST_DONE;
        end else begin
          state_d = cas_pkg::ST_EXP;
        end
      end

      // multiply in one table root for each set fraction bit
      cas_pkg::ST_EXP: begin
        tab_idx = 6'(cas_pkg::LOG_FRAC + 1) - cnt_q;
        mul_a   = {2'b00, acc_q};
        mul_b   = {2'b00, cas_pkg::EXP_TAB[tab_idx[4:0]]};
        if (f_q[cas_pkg::LOG_FRAC-1]) begin
          acc_d = prod[30 +: cas_pkg::DATA_W];
        end
        f_d   = {f_q[cas_pkg::LOG_FRAC-2:0], 1'b0};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == 6'd1) begin
          state_d = cas_pkg::ST_PFIN;
        end
      end

      // scale, sign and clamp the power result
      cas_pkg::ST_PFIN: begin
        mag     = {1'b0, acc_q >> sh_q};
        wide    = neg_q ? -cas_pkg::PROD_W'(mag) : cas_pkg::PROD_W'(mag);
        sat_r   = cas_pkg::sat32(wide);
        res_d   = sat_r.val;
        ovf_d   = sat_r.ovf;
        state_d = cas_pkg::ST_DONE;
      end

      // repeated square, stopping on the first overflow
      cas_pkg::ST_SQR: begin
        mul_a = cas_pkg::MUL_W'($signed(acc_q));
        mul_b = cas_pkg::MUL_W'($signed(acc_q));
        wide  = prod >>> cas_pkg::FRAC_BITS;
        acc_d = wide[cas_pkg::DATA_W-1:0];
        cnt_d = cnt_q - 1'b1;
        if (wide > cas_pkg::S32MAX_W) begin
          res_d   = cas_pkg::S32MAX_W[cas_pkg::DATA_W-1:0];
          ovf_d   = 1'b1;
          state_d = cas_pkg::ST_DONE;
        end else if (cnt_q == 6'd1) begin
          res_d   = wide[cas_pkg::DATA_W-1:0];
          state_d = cas_pkg::ST_DONE;
        end
      end

      // wait for the quotient, then sign it, offset a remap by tgt_lo and clamp it
      cas_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          if (op_mode_q == cas_pkg::OP_DIV) begin
            wide = cas_pkg::PROD_W'(div_rsp.quot);
            if (x_q[cas_pkg::DATA_W-1] ^ num_q[cas_pkg::DATA_W-1]) begin
              wide = -wide;
            end
          end else begin
            qc   = (div_rsp.quot > Q_LIM) ? Q_LIM : div_rsp.quot;
            wide = cas_pkg::PROD_W'(qc);
            if (dx[cas_pkg::DATA_W] ^ dy[cas_pkg::DATA_W] ^ dr[cas_pkg::DATA_W]) begin
              wide = -wide;
            end
            wide = wide + cas_pkg::PROD_W'(tgt_lo_q);
          end
          sat_r   = cas_pkg::sat32(wide);
          res_d   = sat_r.val;
          ovf_d   = sat_r.ovf;
          state_d = cas_pkg::ST_DONE;
        end
      end

      // hand the item to the output register once it is free
      cas_pkg::ST_DONE: begin
        if (!ov_q || out_o.ready) begin
          ov_d    = 1'b1;
          os_d    = res_q;
          oo_d    = ovf_q;
          od_d    = dom_q;
          state_d = cas_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = cas_pkg::ST_IDLE;
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_mode_q <= cas_pkg::OP_ADD;
      num_q     <= '0;
      src_lo_q  <= '0;
      src_hi_q  <= ONE_Q;
      tgt_lo_q  <= '0;
      tgt_hi_q  <= ONE_Q;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cas_pkg::CFG_OP_MODE: op_mode_q <= cfg_data_i[2:0];
        cas_pkg::CFG_OPERAND: num_q     <= cfg_data_i;
        cas_pkg::CFG_SRC_LO:  src_lo_q  <= cfg_data_i;
        cas_pkg::CFG_SRC_HI:  src_hi_q  <= cfg_data_i;
        cas_pkg::CFG_TGT_LO:  tgt_lo_q  <= cfg_data_i;
        cas_pkg::CFG_TGT_HI:  tgt_hi_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cas_pkg::ST_IDLE;
      ov_q    <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      cnt_q   <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    acc_q  <= acc_d;
    p_q    <= p_d;
    frac_q <= frac_d;
    f_q    <= f_d;
    sh_q   <= sh_d;
    neg_q  <= neg_d;
    res_q  <= res_d;
    ovf_q  <= ovf_d;
    dom_q  <= dom_d;
    os_q   <= os_d;
    oo_q   <= oo_d;
    od_q   <= od_d;
  end

  assign in_i.ready          = (state_q == cas_pkg::ST_IDLE);
  assign out_o.valid         = ov_q;
  assign out_o.sample_out    = os_q;
  assign out_o.overflow_flag = oo_q;
  assign out_o.domain_flag   = od_q;

  // checks on the sequencer and result flags
`include "assert_macros.svh"
  `CAS_ASSERT_NEXT(a_accept_busy, in_i.valid && in_i.ready, state_q != cas_pkg::ST_IDLE)
  `CAS_ASSERT(a_div_wait, state_q == cas_pkg::ST_DIV |-> div_rsp.busy || div_rsp.done)
  `CAS_ASSERT(a_flags_excl, out_o.valid |-> !(out_o.overflow_flag && out_o.domain_flag))

endmodule

[rtl/core/cas_div.sv]
// restoring unsigned divider, one quotient bit per cycle
module cas_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cas_pkg::div_req_t req_i,
  output cas_pkg::div_rsp_t rsp_o
);

  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [cas_pkg::DCNT_W-1:0]   cnt_q, cnt_d;
  logic [cas_pkg::DVD_W-1:0]    dvd_q, dvd_d;
  logic [cas_pkg::DVD_W-1:0]    quo_q, quo_d;
  logic [cas_pkg::DVS_W-1:0]    dvs_q, dvs_d;
  logic [cas_pkg::DVS_W:0]      rem_q, rem_d;
  logic [cas_pkg::DVS_W:0]      rem_sh;
  logic [cas_pkg::DVS_W:0]      rem_sub;
  logic                         fits;

  // shift in the next dividend bit and try the subtract
  always_comb begin
    rem_sh  = {rem_q[cas_pkg::DVS_W-1:0], dvd_q[cas_pkg::DVD_W-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    fits    = (rem_sh >= {1'b0, dvs_q});
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    dvd_d   = dvd_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    rem_d   = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.nbits;
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      quo_d  = '0;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[cas_pkg::DVD_W-2:0], 1'b0};
      rem_d = fits ? rem_sub : rem_sh;
      quo_d = {quo_q[cas_pkg::DVD_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == cas_pkg::DCNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule

[dv/tb_configurable_arith_stage_unit.sv]
// self-checking testbench of the configurable arithmetic stage
module tb_configurable_arith_stage_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int               WATCHDOG_LIMIT = 20000;
  localparam int               SETTLE_CYCLES  = 120;
  localparam logic [2:0]       OP_UNUSED      = 3'd7;
  localparam longint           SMAX           = 64'sd2147483647;
  localparam longint           SMIN           = -64'sd2147483648;

  typedef struct {
    logic [31:0] val;
    logic        ovf;
    logic        dom;
  } arith_res_t;

  // mirror of the stage's arithmetic with its own copy of the registers
  class arith_scoreboard;
    logic [2:0]  mode;
    longint      num, src_lo, src_hi, tgt_lo, tgt_hi;
    bit [63:0]   root_tab [25];
    arith_res_t  pending_q [$];
    int          errors;

    function new();
      mode   = cas_pkg::OP_ADD;
      num    = 0;
      src_lo = 0;
      src_hi = 65536;
      tgt_lo = 0;
      tgt_hi = 65536;
      errors = 0;
      root_tab[0] = 64'h1 << 31;
      for (int i = 1; i <= 24; i++) root_tab[i] = int_sqrt(root_tab[i-1] << 30);
    endfunction

    function bit [63:0] int_sqrt(bit [63:0] v);
      bit [63:0] res, b;
      res = 0;
      b   = 64'h1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v   = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function longint clamp(longint v, ref bit ovf);
      if (v > SMAX) begin
        ovf = 1;
        return SMAX;
      end
      if (v < SMIN) begin
        ovf = 1;
        return SMIN;
      end
      return v;
    endfunction

    // log2 in q.24 by leading one and mantissa squaring
    function longint log2_fix(bit [31:0] u);
      int        p;
      bit [63:0] mn, fr;
      p  = 31;
      fr = 0;
      while (p > 0 && u[p] == 1'b0) p--;
      mn = 64'(u) << (31 - p);
      for (int i = 0; i < 24; i++) begin
        mn = (mn * mn) >> 31;
        fr = fr << 1;
        if (mn >= 64'h1_0000_0000) begin
          fr = fr | 1;
          mn = mn >> 1;
        end
      end
      return longint'(p - cas_pkg::FRAC_BITS) * (64'sd1 << 24) + longint'(fr);
    endfunction

    function longint exp2_fix(longint e, ref bit ovf);
      longint    k, s;
      bit [63:0] f, r;
      k = e >>> 24;
      f = e - k * (64'sd1 << 24);
      r = 64'h1 << 30;
      for (int i = 1; i <= 24; i++)
        if (f[24-i]) r = (r * root_tab[i]) >> 30;
      s = k + cas_pkg::FRAC_BITS;
      if (s >= 31) begin
        ovf = 1;
        return SMAX + 1;
      end
      if (30 - s > 31) return 0;
      return longint'(r >> (30 - s));
    endfunction

    function longint power_of(longint x, ref bit ovf, ref bit dom);
      bit        neg;
      bit [31:0] u;
      longint    mag;
      neg = 0;
      if (x == 0) begin
        if (num > 0) return 0;
        if (num == 0) return 64'sd1 << cas_pkg::FRAC_BITS;
        ovf = 1;
        return SMAX;
      end
      if (x < 0) begin
        // fractional exponent of a negative base
        if (num[15:0] != 0) begin
          dom = 1;
          return 0;
        end
        neg = num[16];
      end
      u   = (x < 0) ? 32'(-x) : 32'(x);
      mag = exp2_fix((num * log2_fix(u)) >>> cas_pkg::FRAC_BITS, ovf);
      return clamp(neg ? -mag : mag, ovf);
    endfunction

    function arith_res_t compute(logic [31:0] sample);
      longint     x, r, c, dx, dr, dy;
      bit [63:0]  q;
      bit         ovf, dom, neg;
      arith_res_t res;
      x   = longint'(signed'(sample));
      r   = x;
      ovf = 0;
      dom = 0;
      case (mode)
        cas_pkg::OP_ADD:   r = clamp(x + num, ovf);
        cas_pkg::OP_MUL:   r = clamp((x * num) >>> cas_pkg::FRAC_BITS, ovf);
        cas_pkg::OP_DIV:   r = clamp((x * 65536) / ((num != 0) ? num : 64'sd1), ovf);
        cas_pkg::OP_POW:   r = power_of(x, ovf, dom);
        cas_pkg::OP_SQR: begin
          c = num >>> cas_pkg::FRAC_BITS;
          if (c > cas_pkg::MAX_SQUARINGS) c = cas_pkg::MAX_SQUARINGS;
          for (longint i = 0; i < c; i++) begin
            r = (r * r) >>> cas_pkg::FRAC_BITS;
            if (r > SMAX) begin
              r   = SMAX;
              ovf = 1;
              break;
            end
          end
        end
        cas_pkg::OP_REMAP: begin
          dx = x - src_lo;
          dr = src_hi - src_lo;
          dy = tgt_hi - tgt_lo;
          if (dr == 0) begin
            // empty source range
            dom = 1;
            r   = 0;
          end else begin
            q = 64'((dx < 0) ? -dx : dx) * 64'((dy < 0) ? -dy : dy);
            q = q / 64'((dr < 0) ? -dr : dr);
            if (q > (64'h1 << 40)) q = 64'h1 << 40;
            neg = ((dx < 0) != (dy < 0)) != (dr < 0);
            r   = clamp(tgt_lo + (neg ? -longint'(q) : longint'(q)), ovf);
          end
        end
        cas_pkg::OP_REPL:  r = num;
        default:  r = x;
      endcase
      res.val = r[31:0];
      res.ovf = ovf;
      res.dom = dom;
      return res;
    endfunction

    function void set_reg(cas_pkg::cfg_idx_e idx, logic [31:0] d);
      case (idx)
        cas_pkg::CFG_OP_MODE: mode   = d[2:0];
        cas_pkg::CFG_OPERAND: num    = longint'(signed'(d));
        cas_pkg::CFG_SRC_LO:  src_lo = longint'(signed'(d));
        cas_pkg::CFG_SRC_HI:  src_hi = longint'(signed'(d));
        cas_pkg::CFG_TGT_LO:  tgt_lo = longint'(signed'(d));
        cas_pkg::CFG_TGT_HI:  tgt_hi = longint'(signed'(d));
        default: ;
      endcase
    endfunction

    function void note_sample(logic [31:0] sample);
      pending_q.push_back(compute(sample));
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task check_result(logic [31:0] val, logic ovf, logic dom);
      arith_res_t e;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected item %h", val));
        return;
      end
      e = pending_q.pop_front();
      if (val !== e.val) report($sformatf("sample_out %h, want %h", val, e.val));
      if (ovf !== e.ovf) report($sformatf("overflow_flag %b, want %b", ovf, e.ovf));
      if (dom !== e.dom) report($sformatf("domain_flag %b, want %b", dom, e.dom));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = '0;
  logic [31:0] cfg_data = '0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          quiet_cycles = 0;

  arith_scoreboard sb = new();

  cas_in_if  in_if();
  cas_out_if out_if();

  initial begin
    in_if.valid     = 1'b0;
    in_if.sample_in = '0;
    out_if.ready    = 1'b0;
  end

  configurable_arith_stage_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #10 clk_i = ~clk_i;

  // sink side: random stalls
  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // monitors and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        sb.note_sample(in_if.sample_in);
      end
      if (out_if.valid && out_if.ready) begin
        sb.check_result(out_if.sample_out, out_if.overflow_flag, out_if.domain_flag);
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task write_reg(cas_pkg::cfg_idx_e idx, logic [31:0] d);
    @(negedge clk_i);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = d;
    sb.set_reg(idx, d);
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  // wait for every outstanding item, then let the sequencer settle
  task drain();
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // random idle cycles first, then hold the item until it is taken
  task send_sample(logic [31:0] s);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid     = 1'b1;
    in_if.sample_in = s;
    forever begin
      @(posedge clk_i);
      if (in_if.ready) break;
    end
  endtask

  task finish_burst();
    @(negedge clk_i);
    in_if.valid = 1'b0;
  endtask

  // one directed item under a fresh mode and operand
  task directed(logic [2:0] m, logic [31:0] n, logic [31:0] x);
    drain();
    write_reg(cas_pkg::CFG_OP_MODE, m);
    write_reg(cas_pkg::CFG_OPERAND, n);
    send_sample(x);
    finish_burst();
  endtask

  // mixed-distribution 32-bit value: extremes, small, integral, mid-range or anything
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      1:       return 32'($signed($urandom_range(0, 8191)) - 4096);
      2:       return 32'($signed($urandom_range(0, 64)) - 32) << 16;
      3:       return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_operand(logic [2:0] m);
    case (m)
      cas_pkg::OP_POW: begin
        case ($urandom_range(0, 3))
          0:       return 32'($signed($urandom_range(0, 8)) - 3) << 16;
          1:       return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
          2:       return 32'h0;
          default: return pick_word();
        endcase
      end
      cas_pkg::OP_SQR: begin
        if ($urandom_range(0, 3) == 0) return pick_word();
        return (32'($urandom_range(0, 6)) << 16) | 32'($urandom_range(0, 65535));
      end
      cas_pkg::OP_DIV:  return ($urandom_range(0, 7) == 0) ? 32'h0 : pick_word();
      default: return pick_word();
    endcase
  endfunction

  function automatic logic [31:0] pick_sample(logic [2:0] m);
    if (m == cas_pkg::OP_SQR && $urandom_range(0, 1))
      return 32'($urandom_range(0, 1 << 18)) - (1 << 17);
    if (m == cas_pkg::OP_POW && $urandom_range(0, 1))
      return 32'($urandom_range(0, 1 << 20)) - (1 << 19);
    return pick_word();
  endfunction

  initial begin
    logic [2:0] m;
    logic       tight;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes and special cases
    directed(cas_pkg::OP_ADD,   32'h7fff_ffff, 32'h7fff_ffff);
    directed(cas_pkg::OP_ADD,   32'h8000_0000, 32'h8000_0000);
    directed(cas_pkg::OP_MUL,   32'h0002_0000, 32'hc000_0000);
    directed(cas_pkg::OP_MUL,   32'h8000_0000, 32'h8000_0000);
    directed(cas_pkg::OP_DIV,   32'h0,         32'h0001_8000);
    directed(cas_pkg::OP_DIV,   32'hffff_ffff, 32'h8000_0000);
    directed(cas_pkg::OP_DIV,   32'hfffe_0000, 32'h0003_0000);
    directed(cas_pkg::OP_POW,   32'h0001_8000, 32'hfffe_0000);
    directed(cas_pkg::OP_POW,   32'h0003_0000, 32'hfffe_0000);
    directed(cas_pkg::OP_POW,   32'h0002_0000, 32'hfffd_0000);
    directed(cas_pkg::OP_POW,   32'h0002_0000, 32'h0);
    directed(cas_pkg::OP_POW,   32'h0,         32'h0);
    directed(cas_pkg::OP_POW,   32'hffff_0000, 32'h0);
    directed(cas_pkg::OP_POW,   32'h0000_8000, 32'h0004_0000);
    directed(cas_pkg::OP_POW,   32'h0020_0000, 32'h7fff_ffff);
    directed(cas_pkg::OP_SQR,   32'h0,         32'h0003_0000);
    directed(cas_pkg::OP_SQR,   32'hfffe_0000, 32'h0003_0000);
    directed(cas_pkg::OP_SQR,   32'h7fff_ffff, 32'h0001_0001);
    directed(cas_pkg::OP_SQR,   32'h0003_8000, 32'hfffe_8000);
    directed(cas_pkg::OP_REPL,  32'h8000_0000, 32'h1234_5678);
    directed(OP_UNUSED,         32'h0,         32'h8765_4321);
    // empty source range, then a reversed wide remap
    drain();
    write_reg(cas_pkg::CFG_SRC_HI, 32'h0);
    directed(cas_pkg::OP_REMAP, 32'h0, 32'h0001_0000);
    drain();
    write_reg(cas_pkg::CFG_SRC_LO, 32'h8000_0000);
    write_reg(cas_pkg::CFG_SRC_HI, 32'h7fff_ffff);
    write_reg(cas_pkg::CFG_TGT_LO, 32'h7fff_ffff);
    write_reg(cas_pkg::CFG_TGT_HI, 32'h8000_0000);
    directed(cas_pkg::OP_REMAP, 32'h0, 32'h8000_0000);
    directed(cas_pkg::OP_REMAP, 32'h0, 32'h7fff_ffff);

    // random phases, each with its own setting and idling pattern
    for (int ph = 0; ph < 32; ph++) begin
      drain();
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 77; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 77; end
        default: begin send_idle_pct = 10; stall_pct = 10; end
      endcase
      m = (ph < 8) ? 3'(ph) : 3'($urandom_range(0, 7));
      write_reg(cas_pkg::CFG_OP_MODE, m);
      write_reg(cas_pkg::CFG_OPERAND, pick_operand(m));
      if (m == cas_pkg::OP_REMAP) begin
        // mostly narrow ranges so that results stay in range
        tight = $urandom_range(0, 3) != 0;
        write_reg(cas_pkg::CFG_SRC_LO,
                  tight ? 32'($urandom_range(0, 1 << 20)) - (1 << 19) : pick_word());
        write_reg(cas_pkg::CFG_SRC_HI,
                  tight ? 32'($urandom_range(0, 1 << 20)) - (1 << 19) : pick_word());
        write_reg(cas_pkg::CFG_TGT_LO,
                  tight ? 32'($urandom_range(0, 1 << 22)) - (1 << 21) : pick_word());
        write_reg(cas_pkg::CFG_TGT_HI,
                  tight ? 32'($urandom_range(0, 1 << 22)) - (1 << 21) : pick_word());
      end
      for (int i = 0; i < 50; i++) send_sample(pick_sample(m));
      finish_burst();
    end

    drain();
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
